FILE: sv/fpfa_pkg.sv
// Shared codes and widths for the fixed-partition fit allocator.
`default_nettype none

package fpfa_pkg;

  // Item mode codes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_REQ   = 2'd1;
  localparam logic [1:0] MODE_BATCH = 2'd2;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT_POLICY    = 2'd0;
  localparam logic [1:0] CFG_FRAMES_IN_USE = 2'd1;

  // Fixed field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned SIZEIN_W = 16;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned CFGDAT_W = 5;

  localparam logic [CFGDAT_W-1:0] FRAMES_RESET = 5'd16;

endpackage

`default_nettype wire

FILE: sv/fpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/fixed_partition_fit_allocator.sv
// Top level: fixed-partition allocator with first, best and worst fit search.
//
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------------
// in       | sink      | in_valid_i / in_ready_o  | mode_i, frame_index_i, size_value_i
// out      | source    | out_valid_o / out_ready_i| granted_o, granted_frame_o
// cfg      | sink      | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// Load and new-batch beats finish in the cycle they are accepted.
// A request scans N = min(frames_in_use, NUM_FRAMES) partitions, one compare per
// partition, paced by the single read port of the size RAM, whose read data is
// registered. First fit stops at the first hit. An empty search (N = 0) skips
// the scan and goes straight to RESULT.
// The result sits in an output register; loads and batch beats are still taken
// while it waits, a request finishing behind an untaken result holds in RESULT.
// Reset clears the used bits and the sequencer and sets the config to its defaults;
// the size RAM is not cleared and must be loaded before it is searched.
`default_nettype none

module fixed_partition_fit_allocator #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [fpfa_pkg::CFGIDX_W-1:0]       cfg_idx_i,
  input  wire logic [fpfa_pkg::CFGDAT_W-1:0]       cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [fpfa_pkg::MODE_W-1:0]         mode_i,
  input  wire logic [fpfa_pkg::FIDX_W-1:0]         frame_index_i,
  input  wire logic [fpfa_pkg::SIZEIN_W-1:0]       size_value_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     granted_o,
  output logic [fpfa_pkg::FIDX_W-1:0]              granted_frame_o
);

  localparam int unsigned AW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [1:0]                     policy_q, policy_d;
  logic [fpfa_pkg::CFGDAT_W-1:0]  frames_q, frames_d;
  logic [NUM_FRAMES-1:0]          used_q, used_d;
  logic [CW-1:0]                  issue_q, issue_d;
  logic                           rd_vld_q, rd_vld_d;
  logic [AW-1:0]                  rd_idx_q, rd_idx_d;
  logic                           found_q, found_d;
  logic [SIZE_BITS-1:0]           best_size_q, best_size_d;
  logic [AW-1:0]                  best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0]           req_q, req_d;
  logic                           out_valid_q, out_valid_d;
  logic                           granted_q, granted_d;
  logic [fpfa_pkg::FIDX_W-1:0]    frame_q, frame_d;

  logic                           in_beat;
  logic [31:0]                    size_ext;
  logic [SIZE_BITS-1:0]           size_trim;
  logic [31:0]                    frames_ext;
  logic [CW-1:0]                  count;
  logic                           load_ok;
  logic                           ram_we;
  logic                           ram_re;
  logic [SIZE_BITS-1:0]           ram_rdata;
  logic                           entry_used;
  logic                           ge_req;      // shared compare: entry vs request
  logic                           lt_best;     // shared compare: entry vs best so far
  logic                           last_entry;
  logic                           grant;
  logic                           out_free;

  assign in_beat    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // request/size field trimmed or widened to the table width
  assign size_ext  = {16'd0, size_value_i};
  assign size_trim = size_ext[SIZE_BITS-1:0];

  // search count saturates at the table depth
  assign frames_ext = 32'(frames_q);
  assign count      = (frames_ext > 32'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(frames_ext);

  assign load_ok = (32'(frame_index_i) < 32'(NUM_FRAMES));
  assign ram_we  = in_beat && (mode_i == fpfa_pkg::MODE_LOAD) && load_ok;
  assign ram_re  = (state_q == ST_SCAN) && (issue_q < count);

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_FRAMES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(frame_index_i)),
    .wdata_i (size_trim),
    .re_i    (ram_re),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // evaluation of the entry whose size just came out of the RAM
  assign entry_used = used_q[rd_idx_q];
  assign ge_req     = (ram_rdata >= req_q);
  assign lt_best    = (policy_q == fpfa_pkg::POL_WORST) ? (ram_rdata > best_size_q)
                                                        : (ram_rdata < best_size_q);
  assign last_entry = (CW'(rd_idx_q) == (count - CW'(1)));

  // worst fit only checks the request against the largest free entry at the end
  assign grant    = found_q &&
                    ((policy_q != fpfa_pkg::POL_WORST) || (best_size_q >= req_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    policy_d    = policy_q;
    frames_d    = frames_q;
    used_d      = used_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_size_d = best_size_q;
    best_idx_d  = best_idx_q;
    req_d       = req_q;
    out_valid_d = out_valid_q && !out_ready_i;
    granted_d   = granted_q;
    frame_d     = frame_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpfa_pkg::CFG_FIT_POLICY:    policy_d = cfg_data_i[1:0];
        fpfa_pkg::CFG_FRAMES_IN_USE: frames_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          unique case (mode_i)
            fpfa_pkg::MODE_BATCH: used_d = '0;
            fpfa_pkg::MODE_REQ: begin
              req_d   = size_trim;
              issue_d = '0;
              found_d = 1'b0;
              state_d = (count == '0) ? ST_RESULT : ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (ram_re) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[AW-1:0];
          issue_d  = issue_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (!entry_used) begin
            unique case (policy_q)
              fpfa_pkg::POL_FIRST: begin
                if (ge_req) begin
                  found_d    = 1'b1;
                  best_idx_d = rd_idx_q;
                  state_d    = ST_RESULT;
                end
              end
              fpfa_pkg::POL_BEST: begin
                if (ge_req && (!found_q || lt_best)) begin
                  found_d     = 1'b1;
                  best_size_d = ram_rdata;
                  best_idx_d  = rd_idx_q;
                end
              end
              fpfa_pkg::POL_WORST: begin
                if (!found_q || lt_best) begin
                  found_d     = 1'b1;
                  best_size_d = ram_rdata;
                  best_idx_d  = rd_idx_q;
                end
              end
              default: ;
            endcase
          end
          if (last_entry) begin
            state_d = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          granted_d   = grant;
          frame_d     = grant ? fpfa_pkg::FIDX_W'(best_idx_q) : '0;
          if (grant) begin
            used_d[best_idx_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= fpfa_pkg::POL_FIRST;
      frames_q    <= fpfa_pkg::FRAMES_RESET;
      used_q      <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      frames_q    <= frames_d;
      used_q      <= used_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_size_q <= best_size_d;
    best_idx_q  <= best_idx_d;
    req_q       <= req_d;
    granted_q   <= granted_d;
    frame_q     <= frame_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign granted_frame_o = frame_q;

endmodule

`default_nettype wire

FILE: sv/fpfa_checker.sv
// Port-level checker for the fixed-partition fit allocator, bound to the top level.
`default_nettype none

module fpfa_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic [fpfa_pkg::MODE_W-1:0]    mode_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           granted_o,
  input wire logic [fpfa_pkg::FIDX_W-1:0]    granted_frame_o
);

  // a request keeps the block busy for at least the next cycle
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == fpfa_pkg::MODE_REQ)) |=> !in_ready_o)
    else $error("request beat did not make the block busy");

  // loads, batch and unused modes never leave the block busy
  a_ctl_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i != fpfa_pkg::MODE_REQ)) |=> in_ready_o)
    else $error("non-request beat left the block busy");

  // refused requests report frame zero
  a_deny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (granted_frame_o == '0))
    else $error("refused request carries a nonzero frame");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(granted_o) && $stable(granted_frame_o)))
    else $error("stalled result changed");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .mode_i          (mode_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_o       (granted_o),
  .granted_frame_o (granted_frame_o)
);

`default_nettype wire
